>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define DBQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define DBQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/dbq_pkg.sv
package dbq_pkg;

    localparam int MAX_RECTS  = 1024;
    localparam int MAX_TRACKS = 256;
    localparam int COORD_W    = 32;

    localparam int RECT_AW = $clog2(MAX_RECTS);
    localparam int RCNT_W  = RECT_AW + 1;
    localparam int TRK_AW  = $clog2(MAX_TRACKS);
    localparam int TCNT_W  = TRK_AW + 1;
    localparam int DBL_W   = COORD_W + 2;
    localparam int GAP_W   = COORD_W + 3;
    localparam int SQ_W    = 2 * COORD_W;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCNT_W = QAW + 1;

    localparam int IN_W  = 168;
    localparam int OUT_W = 144;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_RECT  = 3'd1;
    localparam logic [2:0] CMD_XTRK  = 3'd2;
    localparam logic [2:0] CMD_YTRK  = 3'd3;
    localparam logic [2:0] CMD_QUERY = 3'd4;

    localparam logic [1:0] MODE_SIDE   = 2'd0;
    localparam logic [1:0] MODE_TIP    = 2'd1;
    localparam logic [1:0] MODE_CORNER = 2'd2;

    localparam int BIT_L  = 0;
    localparam int BIT_R  = 1;
    localparam int BIT_T  = 2;
    localparam int BIT_B  = 3;
    localparam int BIT_TL = 0;
    localparam int BIT_TR = 1;
    localparam int BIT_BL = 2;
    localparam int BIT_BR = 3;

    localparam logic signed [COORD_W-1:0] NO_TRACK = -2;

    typedef enum logic [2:0] {OP_CLEAR, OP_RECT, OP_XTRK, OP_YTRK, OP_QUERY, OP_NOP} t_op;

    typedef enum logic [1:0] {PD_H, PD_V, PD_BI, PD_PT} t_pdir;

    typedef enum logic [3:0] {
        BS_IDLE, BS_CTR, BS_NBR1, BS_NBR2, BS_WIN, BS_RD, BS_GAP,
        BS_SQ, BS_EVAL, BS_WRD, BS_WCHK, BS_DONE
    } t_bstate;

    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  a;
        logic signed [COORD_W-1:0]  b;
        logic signed [COORD_W-1:0]  c;
        logic signed [COORD_W-1:0]  d;
        logic [7:0]                 layer;
        logic [7:0]                 xp;
        logic [7:0]                 yp;
        logic [7:0]                 z;
        logic [1:0]                 mode;
    } t_item;

    typedef struct packed {
        logic [7:0]                 layer;
        logic signed [COORD_W-1:0]  hy;
        logic signed [COORD_W-1:0]  hx;
        logic signed [COORD_W-1:0]  ly;
        logic signed [COORD_W-1:0]  lx;
    } t_rect;

    typedef struct packed {
        logic [2:0]                 pad;
        logic [7:0]                 level;
        logic [COORD_W-1:0]         e3;
        logic [COORD_W-1:0]         e2;
        logic [COORD_W-1:0]         e1;
        logic [COORD_W-1:0]         e0;
        logic                       ev;
        logic [3:0]                 mask;
    } t_result;

    function automatic logic signed [DBL_W-1:0] dbl(input logic signed [COORD_W-1:0] v);
        return {v[COORD_W-1], v, 1'b0};
    endfunction

    function automatic logic signed [DBL_W-1:0] ext(input logic signed [COORD_W-1:0] v);
        return {{2{v[COORD_W-1]}}, v};
    endfunction

    // half-nm to nm, rounding toward minus infinity
    function automatic logic [COORD_W-1:0] to_nm(input logic signed [COORD_W-1:0] v);
        return {v[COORD_W-1], v[COORD_W-1:1]};
    endfunction

    function automatic t_pdir classify(input logic signed [COORD_W:0] w,
                                       input logic signed [COORD_W:0] h,
                                       input logic signed [COORD_W:0] thr);
        t_pdir r;
        if (w <= thr && h <= thr)     r = PD_PT;
        else if (w > thr && h <= thr) r = PD_H;
        else if (h > thr && w <= thr) r = PD_V;
        else                          r = PD_BI;
        return r;
    endfunction

endpackage

>>> hw/rtl/dbq_ram.sv
module dbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/dbq_front.sv
module dbq_front
    import dbq_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic [2:0]      s_tuser,
    output logic            o_valid,
    output t_item           o_item,
    input  logic            i_pop
);

    t_item             r_q [QDEPTH];
    logic [QAW-1:0]    r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    t_item             n_item;
    logic              push;

    always_comb begin
        unique case (s_tuser)
            CMD_CLEAR: n_item.op = OP_CLEAR;
            CMD_RECT:  n_item.op = OP_RECT;
            CMD_XTRK:  n_item.op = OP_XTRK;
            CMD_YTRK:  n_item.op = OP_YTRK;
            CMD_QUERY: n_item.op = OP_QUERY;
            default:   n_item.op = OP_NOP;
        endcase
        n_item.a     = s_tdata[31:0];
        n_item.b     = s_tdata[63:32];
        n_item.c     = s_tdata[95:64];
        n_item.d     = s_tdata[127:96];
        n_item.layer = s_tdata[135:128];
        n_item.xp    = s_tdata[143:136];
        n_item.yp    = s_tdata[151:144];
        n_item.z     = s_tdata[159:152];
        n_item.mode  = s_tdata[161:160];
    end

    assign s_tready = (r_cnt != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign o_valid  = (r_cnt != '0);
    assign o_item   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_item;
        end
    end

endmodule

>>> hw/rtl/dbq_back.sv
module dbq_back
    import dbq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    t_bstate r_state, n_state;
    t_item   r_it;

    logic [RCNT_W-1:0] r_rcnt;
    logic [TCNT_W-1:0] r_xcnt, r_ycnt;
    logic [RECT_AW-1:0] r_idx;

    logic signed [COORD_W-1:0] r_x, r_y, r_rx, r_lx, r_uy, r_dy;
    logic signed [DBL_W-1:0]   r_ilx, r_iux, r_ily, r_iuy;
    logic signed [GAP_W-1:0]   r_dd;
    logic [SQ_W-1:0]           r_ddsq;

    logic signed [DBL_W-1:0]   r_px0, r_py0, r_px1, r_py1;
    logic signed [GAP_W-1:0]   r_gx, r_gy;
    t_pdir                     r_pdir;
    logic [SQ_W-1:0]           r_sqx, r_sqy;

    logic [TRK_AW-1:0]         r_k;
    logic                      r_wup, r_wonx;
    logic signed [DBL_W-1:0]   r_woff, r_wtgt, r_wbnd;
    logic signed [COORD_W-1:0] r_wf0, r_wf1;

    logic [3:0]         r_mask;
    logic               r_ev;
    logic [COORD_W-1:0] r_e0, r_e1, r_e2, r_e3;

    logic    r_m_valid;
    t_result r_m_data;

    // memories
    logic               rect_we, x_we, y_we;
    t_rect              rect_wdata, rect_rdata;
    logic [TRK_AW-1:0]  x_raddr, y_raddr;
    logic [COORD_W-1:0] x_rdata, y_rdata;

    logic start, q_ok, more_rects, out_take;

    // rect stage signals
    logic signed [DBL_W-1:0] g_px0, g_py0, g_px1, g_py1;
    logic signed [GAP_W-1:0] g_gxa, g_gxb, g_gya, g_gyb, g_gx, g_gy;
    logic                    g_layer_ok, s_far;
    logic [COORD_W-1:0]      gxu, gyu, ddu;
    logic [SQ_W:0]           e_sum;
    logic                    e_hit, ox, oy, rc, lc, tc, bc, sidebit;
    logic [3:0]              e_set;
    logic                    e_walk, e_wup, e_wonx;
    logic [TRK_AW-1:0]       e_k;
    logic signed [DBL_W-1:0] e_off, e_tgt, e_bnd;
    logic signed [COORD_W-1:0] e_f0, e_f1;

    // walk step signals
    logic signed [COORD_W-1:0] w_t;
    logic signed [DBL_W-1:0]   w_m2;
    logic                      w_brk, w_hit, w_more;

    dbq_ram #(.WIDTH($bits(t_rect)), .DEPTH(MAX_RECTS)) u_rect_ram (
        .i_clk   (i_clk),
        .i_we    (rect_we),
        .i_waddr (r_rcnt[RECT_AW-1:0]),
        .i_wdata (rect_wdata),
        .i_raddr (r_idx),
        .o_rdata (rect_rdata)
    );

    dbq_ram #(.WIDTH(COORD_W), .DEPTH(MAX_TRACKS)) u_xtrk_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (TRK_AW'(i_item.xp)),
        .i_wdata (i_item.a),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    dbq_ram #(.WIDTH(COORD_W), .DEPTH(MAX_TRACKS)) u_ytrk_ram (
        .i_clk   (i_clk),
        .i_we    (y_we),
        .i_waddr (TRK_AW'(i_item.yp)),
        .i_wdata (i_item.a),
        .i_raddr (y_raddr),
        .o_rdata (y_rdata)
    );

    assign start = (r_state == BS_IDLE) && i_valid;
    assign o_pop = start;
    assign q_ok  = (int'(i_item.xp) < int'(r_xcnt)) && (int'(i_item.yp) < int'(r_ycnt));

    assign rect_we    = start && (i_item.op == OP_RECT) && (int'(r_rcnt) < MAX_RECTS);
    assign x_we       = start && (i_item.op == OP_XTRK) && (int'(i_item.xp) < MAX_TRACKS);
    assign y_we       = start && (i_item.op == OP_YTRK) && (int'(i_item.yp) < MAX_TRACKS);
    assign rect_wdata = '{layer: i_item.layer, hy: i_item.d, hx: i_item.c,
                          ly: i_item.b, lx: i_item.a};

    assign more_rects = (({1'b0, r_idx} + 1'b1) < r_rcnt);
    assign out_take   = (r_state == BS_DONE) && (!r_m_valid || m_tready);

    always_comb begin
        unique case (r_state)
            BS_CTR:  begin
                x_raddr = TRK_AW'(r_it.xp);
                y_raddr = TRK_AW'(r_it.yp);
            end
            BS_NBR1: begin
                x_raddr = TRK_AW'(r_it.xp) + 1'b1;
                y_raddr = TRK_AW'(r_it.yp) + 1'b1;
            end
            BS_NBR2: begin
                x_raddr = TRK_AW'(r_it.xp) - 1'b1;
                y_raddr = TRK_AW'(r_it.yp) - 1'b1;
            end
            default: begin
                x_raddr = r_k;
                y_raddr = r_k;
            end
        endcase
    end

    // distance stage
    always_comb begin
        g_px0 = dbl(rect_rdata.lx);
        g_py0 = dbl(rect_rdata.ly);
        g_px1 = dbl(rect_rdata.hx);
        g_py1 = dbl(rect_rdata.hy);
        g_gxa = GAP_W'(g_px0) - GAP_W'(r_iux);
        g_gxb = GAP_W'(r_ilx) - GAP_W'(g_px1);
        g_gya = GAP_W'(g_py0) - GAP_W'(r_iuy);
        g_gyb = GAP_W'(r_ily) - GAP_W'(g_py1);
        g_gx  = (g_gxa > g_gxb) ? g_gxa : g_gxb;
        g_gy  = (g_gya > g_gyb) ? g_gya : g_gyb;
        if (g_gx < 0) g_gx = '0;
        if (g_gy < 0) g_gy = '0;
        g_layer_ok = (rect_rdata.layer == r_it.layer);
        s_far = (r_gx >= r_dd) || (r_gy >= r_dd);
        gxu   = r_gx[COORD_W-1:0];
        gyu   = r_gy[COORD_W-1:0];
        ddu   = {r_it.c[COORD_W-2:0], 1'b0};
    end

    // classification of one in-range rectangle
    always_comb begin
        e_sum   = (SQ_W+1)'(r_sqx) + (SQ_W+1)'(r_sqy);
        e_hit   = e_sum < (SQ_W+1)'(r_ddsq);
        ox      = (r_ilx < r_px1) && (r_iux > r_px0);
        oy      = (r_ily < r_py1) && (r_iuy > r_py0);
        rc      = r_px0 > r_iux;
        lc      = r_px1 < r_ilx;
        tc      = r_py0 > r_iuy;
        bc      = r_py1 < r_ily;
        e_set   = '0;
        e_walk  = 1'b0;
        e_wup   = 1'b0;
        e_wonx  = 1'b0;
        e_k     = '0;
        e_off   = '0;
        e_tgt   = '0;
        e_bnd   = '0;
        e_f0    = '0;
        e_f1    = '0;
        sidebit = 1'b0;
        if (r_it.mode == MODE_CORNER) begin
            if (!ox && !oy) begin
                if (rc && tc)      e_set[BIT_TR] = 1'b1;
                else if (rc && bc) e_set[BIT_BR] = 1'b1;
                else if (lc && tc) e_set[BIT_TL] = 1'b1;
                else if (lc && bc) e_set[BIT_BL] = 1'b1;
            end
        end else if ((rc || lc) && oy) begin
            sidebit = (r_it.mode == MODE_SIDE && (r_pdir == PD_V || r_pdir == PD_BI)) ||
                      (r_it.mode == MODE_TIP && (r_pdir == PD_H || r_pdir == PD_PT));
            if (sidebit) e_set[rc ? BIT_R : BIT_L] = 1'b1;
            e_f0 = rc ? r_x : r_lx;
            e_f1 = rc ? r_rx : r_x;
            if (r_ily < r_py1 && r_py1 < r_iuy) begin
                e_walk = (r_it.yp != '0);
                e_k    = TRK_AW'(r_it.yp) - 1'b1;
                e_off  = ext(r_it.b);
                e_tgt  = r_py1;
                e_bnd  = r_ily;
            end else if (r_ily < r_py0 && r_py0 < r_iuy) begin
                e_walk = (int'(r_it.yp) + 1 < int'(r_ycnt));
                e_wup  = 1'b1;
                e_k    = TRK_AW'(r_it.yp) + 1'b1;
                e_off  = -ext(r_it.b);
                e_tgt  = r_py0;
                e_bnd  = r_iuy;
            end
        end else if ((tc || bc) && ox) begin
            sidebit = (r_it.mode == MODE_SIDE && (r_pdir == PD_H || r_pdir == PD_BI)) ||
                      (r_it.mode == MODE_TIP && (r_pdir == PD_V || r_pdir == PD_PT));
            if (sidebit) e_set[tc ? BIT_T : BIT_B] = 1'b1;
            e_wonx = 1'b1;
            e_f0   = tc ? r_y : r_dy;
            e_f1   = tc ? r_uy : r_y;
            if (r_ilx < r_px1 && r_px1 < r_iux) begin
                e_walk = (r_it.xp != '0);
                e_k    = TRK_AW'(r_it.xp) - 1'b1;
                e_off  = ext(r_it.a);
                e_tgt  = r_px1;
                e_bnd  = r_ilx;
            end else if (r_ilx < r_px0 && r_px0 < r_iux) begin
                e_walk = (int'(r_it.xp) + 1 < int'(r_xcnt));
                e_wup  = 1'b1;
                e_k    = TRK_AW'(r_it.xp) + 1'b1;
                e_off  = -ext(r_it.a);
                e_tgt  = r_px0;
                e_bnd  = r_iux;
            end
        end
    end

    // one step of a track walk; a break is checked before a match
    always_comb begin
        w_t    = r_wonx ? x_rdata : y_rdata;
        w_m2   = dbl(w_t) + r_woff;
        w_brk  = r_wup ? (r_wbnd < w_m2) : (w_m2 < r_wbnd);
        w_hit  = (w_m2 == r_wtgt);
        w_more = r_wup ? (int'(r_k) + 1 < int'(r_wonx ? r_xcnt : r_ycnt)) : (r_k != '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_valid) begin
                    n_state = (i_item.op == OP_QUERY && q_ok) ? BS_CTR : BS_DONE;
                end
            end
            BS_CTR:  n_state = BS_NBR1;
            BS_NBR1: n_state = BS_NBR2;
            BS_NBR2: n_state = BS_WIN;
            BS_WIN:  n_state = (r_it.c > 0 && r_rcnt != '0) ? BS_RD : BS_DONE;
            BS_RD:   n_state = BS_GAP;
            BS_GAP: begin
                if (g_layer_ok)      n_state = BS_SQ;
                else if (more_rects) n_state = BS_RD;
                else                 n_state = BS_DONE;
            end
            BS_SQ: begin
                if (!s_far)          n_state = BS_EVAL;
                else if (more_rects) n_state = BS_RD;
                else                 n_state = BS_DONE;
            end
            BS_EVAL: begin
                if (e_hit && e_walk) n_state = BS_WRD;
                else if (more_rects) n_state = BS_RD;
                else                 n_state = BS_DONE;
            end
            BS_WRD:  n_state = BS_WCHK;
            BS_WCHK: begin
                if (!w_brk && w_more) n_state = BS_WRD;
                else if (more_rects)  n_state = BS_RD;
                else                  n_state = BS_DONE;
            end
            BS_DONE: begin
                if (!r_m_valid || m_tready) n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcnt    <= '0;
            r_xcnt    <= '0;
            r_ycnt    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (start && i_item.op == OP_CLEAR) begin
                r_rcnt <= '0;
                r_xcnt <= '0;
                r_ycnt <= '0;
            end
            if (rect_we) begin
                r_rcnt <= r_rcnt + 1'b1;
            end
            if (x_we && int'(r_xcnt) < int'(i_item.xp) + 1) begin
                r_xcnt <= TCNT_W'(int'(i_item.xp) + 1);
            end
            if (y_we && int'(r_ycnt) < int'(i_item.yp) + 1) begin
                r_ycnt <= TCNT_W'(int'(i_item.yp) + 1);
            end
            if (out_take) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_it   <= i_item;
            r_mask <= '0;
            r_ev   <= 1'b0;
            r_e0   <= '0;
            r_e1   <= '0;
            r_e2   <= '0;
            r_e3   <= '0;
        end
        if (r_state == BS_NBR1) begin
            r_x <= x_rdata;
            r_y <= y_rdata;
        end
        if (r_state == BS_NBR2) begin
            r_rx <= (int'(r_it.xp) + 1 < int'(r_xcnt)) ? x_rdata : NO_TRACK;
            r_uy <= (int'(r_it.yp) + 1 < int'(r_ycnt)) ? y_rdata : NO_TRACK;
        end
        if (r_state == BS_WIN) begin
            r_lx   <= (r_it.xp != '0) ? x_rdata : NO_TRACK;
            r_dy   <= (r_it.yp != '0) ? y_rdata : NO_TRACK;
            r_ilx  <= dbl(r_x) - ext(r_it.a);
            r_iux  <= dbl(r_x) + ext(r_it.a);
            r_ily  <= dbl(r_y) - ext(r_it.b);
            r_iuy  <= dbl(r_y) + ext(r_it.b);
            r_dd   <= (r_it.c > 0) ? GAP_W'({r_it.c, 1'b0}) : '0;
            r_ddsq <= SQ_W'(ddu) * SQ_W'(ddu);
            r_idx  <= '0;
        end
        if (r_state == BS_GAP) begin
            r_px0  <= g_px0;
            r_py0  <= g_py0;
            r_px1  <= g_px1;
            r_py1  <= g_py1;
            r_gx   <= g_gx;
            r_gy   <= g_gy;
            r_pdir <= classify((COORD_W+1)'(rect_rdata.hx) - (COORD_W+1)'(rect_rdata.lx),
                               (COORD_W+1)'(rect_rdata.hy) - (COORD_W+1)'(rect_rdata.ly),
                               (COORD_W+1)'(r_it.d));
        end
        if (r_state == BS_SQ) begin
            r_sqx <= SQ_W'(gxu) * SQ_W'(gxu);
            r_sqy <= SQ_W'(gyu) * SQ_W'(gyu);
        end
        if (r_state == BS_EVAL && e_hit) begin
            r_mask <= r_mask | e_set;
            r_k    <= e_k;
            r_wup  <= e_wup;
            r_wonx <= e_wonx;
            r_woff <= e_off;
            r_wtgt <= e_tgt;
            r_wbnd <= e_bnd;
            r_wf0  <= e_f0;
            r_wf1  <= e_f1;
        end
        if (r_state == BS_WCHK && !w_brk) begin
            if (w_hit) begin
                r_ev <= 1'b1;
                if (r_wonx) begin
                    r_e0 <= to_nm(w_t);
                    r_e1 <= to_nm(r_wf0);
                    r_e2 <= to_nm(w_t);
                    r_e3 <= to_nm(r_wf1);
                end else begin
                    r_e0 <= to_nm(r_wf0);
                    r_e1 <= to_nm(w_t);
                    r_e2 <= to_nm(r_wf1);
                    r_e3 <= to_nm(w_t);
                end
            end
            r_k <= r_wup ? r_k + 1'b1 : r_k - 1'b1;
        end
        if (n_state == BS_RD && r_state != BS_WIN) begin
            r_idx <= r_idx + 1'b1;
        end
        if (out_take) begin
            r_m_data <= '{pad: '0, level: (r_ev ? r_it.z : 8'd0), e3: r_e3, e2: r_e2,
                          e1: r_e1, e0: r_e0, ev: r_ev, mask: r_mask};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

>>> hw/rtl/directional_blocker_query_core.sv
// Channel   Dir  Transfer carries
// s_*       in   tuser: cmd; tdata: coords a..d, layer, x/y index, level, mode
// m_*       out  tdata: dir_mask, edge_valid, edge x0/y0/x1/y1, edge_level
//
// Loads and clears pass from the queue head through BS_IDLE and BS_DONE to the result register.
// A query reads its tracks (BS_CTR..BS_WIN), then each rect passes BS_RD and BS_GAP; rects
//   on its layer go on to BS_SQ, those within distance to BS_EVAL and then any track walk;
//   the rectangle RAM is read once per rect and each track RAM once per walk step.
// Reset (i_rst_n low, synchronous) empties the queue and zeroes all counts.
// A 2-entry queue takes new transfers while a result waits on m_tready.
module directional_blocker_query_core
    import dbq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // a[31:0] b c d layer x_pos y_pos z_level mode, pad
    input  logic [2:0]       s_tuser,   // cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // dir_mask edge_valid x0 y0 x1 y1 edge_level, pad
);

    logic  item_valid, item_pop;
    t_item item;

    dbq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .o_valid  (item_valid),
        .o_item   (item),
        .i_pop    (item_pop)
    );

    dbq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .i_item   (item),
        .o_pop    (item_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hw/rtl/dbq_checker.sv
`include "assert_macros.svh"

module dbq_props (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    `DBQ_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `DBQ_ASSERT(a_out_stable, i_clk, i_rst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "result moved")
    `DBQ_ASSERT(a_no_edge_zero, i_clk, i_rst_n, m_tvalid && !m_tdata[4] |-> m_tdata[140:5] == 136'd0, "stray segment")
    `DBQ_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !m_tvalid, "valid after reset")

endmodule

bind directional_blocker_query_core dbq_props u_dbq_props (.*);
